[design/sjinv_pkg.sv]
`timescale 1ns / 1ps
package sjinv_pkg;

  // fixed result field widths
  localparam int ENT_W = 32;
  localparam int REC_W = 48;
  // multiplier digit width, bits of the wide operand per cycle
  localparam int DIG_W = 8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SINGULAR = 2'd1,
    ST_COUNT    = 2'd2
  } status_t;

  // job header between front end and back end
  typedef struct packed {
    logic tet;
    logic bad_count;
  } job_hdr_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ADJ2,
    BK_ADJ,
    BK_DET,
    BK_CHK,
    BK_DIVGO,
    BK_DIVW,
    BK_RECIP,
    BK_OUT
  } bk_state_t;

  // index + 1 modulo 3
  function automatic logic [1:0] nx3(input logic [1:0] x);
    return (x == 2'd2) ? 2'd0 : x + 2'd1;
  endfunction

endpackage

[design/sjinv_front.sv]
`timescale 1ns / 1ps
module sjinv_front #(
  parameter int CW = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_elem_kind,
  input  logic [31:0]                in_coord_x,
  input  logic [31:0]                in_coord_y,
  input  logic [31:0]                in_coord_z,
  input  logic                       in_last_vertex,
  input  logic                       q_full,
  output logic                       in_stall,
  output logic                       push,
  output sjinv_pkg::job_hdr_t        hdr,
  output logic [9*(CW+1)-1:0]        jflat
);
  localparam int W = CW + 1;
  localparam logic [2:0] TRI_VTX = 3'd3;
  localparam logic [2:0] TET_VTX = 3'd4;
  localparam logic [2:0] CNT_MAX = 3'd7;
  localparam logic [2:0] STORE_N = 3'd4;

  logic [CW-1:0] vtx_r [4][3];
  logic [CW-1:0] cur   [3];
  logic [CW-1:0] view  [4][3];
  logic [2:0]    cnt_r, cnt_nxt;
  logic          beat;

  assign in_stall = q_full;
  assign beat     = in_valid & ~q_full;
  assign cnt_nxt  = (cnt_r == CNT_MAX) ? CNT_MAX : cnt_r + 3'd1;

  assign cur[0] = CW'(in_coord_x);
  assign cur[1] = CW'(in_coord_y);
  assign cur[2] = CW'(in_coord_z);

  // store contents including this beat's vertex
  always_comb begin
    view = vtx_r;
    if (cnt_r < STORE_N) begin
      for (int k = 0; k < 3; k++) view[cnt_r[1:0]][k] = cur[k];
    end
  end

  // edge Jacobian: column c = vertex c+1 minus vertex 0
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        jflat[(r*3+c)*W +: W] = {view[c+1][r][CW-1], view[c+1][r]}
                              - {view[0][r][CW-1], view[0][r]};
      end
    end
  end

  assign push          = beat & in_last_vertex;
  assign hdr.tet       = in_elem_kind;
  assign hdr.bad_count = cnt_nxt != (in_elem_kind ? TET_VTX : TRI_VTX);

  always_ff @(posedge clk) begin
    if (beat && cnt_r < STORE_N) begin
      for (int k = 0; k < 3; k++) vtx_r[cnt_r[1:0]][k] <= cur[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (beat) begin
      cnt_r <= in_last_vertex ? 3'd0 : cnt_nxt;
    end
  end

endmodule

[design/sjinv_fifo.sv]
`timescale 1ns / 1ps
module sjinv_fifo #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] din,
  input  logic          pop,
  output logic [DW-1:0] dout,
  output logic          full,
  output logic          empty
);
  logic [DW-1:0] mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;

  assign full  = cnt_r == 2'd2;
  assign empty = cnt_r == 2'd0;
  assign dout  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[design/sjinv_div.sv]
`timescale 1ns / 1ps
module sjinv_div #(
  parameter int AW = 67,
  parameter int DW = 102,
  parameter int SH = 33
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [AW-1:0]                 num,
  input  logic signed [DW-1:0]                 den,
  output logic                                 done,
  output logic signed [sjinv_pkg::ENT_W-1:0]   q
);
  localparam int EW  = sjinv_pkg::ENT_W;
  localparam int NW  = ((AW + SH + 1 > DW + 1) ? AW + SH + 1 : DW + 1) + 1;
  localparam int TW  = ((NW > DW + 1 + EW) ? NW : DW + 1 + EW) + 1;
  localparam int CNW = $clog2(EW + 1);

  logic [TW-1:0]  rem_r, dsh_r, nn, dd;
  logic [AW-1:0]  an;
  logic [DW-1:0]  ad;
  logic [EW-1:0]  q_r;
  logic           ovf_r, neg_r, done_r, ge;
  logic [CNW-1:0] cnt_r;

  // rounded quotient (2^(SH+1)|n| + |d|) / (2|d|), restoring, one bit a cycle
  assign an = num[AW-1] ? AW'(-num) : AW'(num);
  assign ad = den[DW-1] ? DW'(-den) : DW'(den);
  assign nn = (TW'(an) << (SH + 1)) + TW'(ad);
  assign dd = TW'(ad) << 1;
  assign ge = rem_r >= dsh_r;
  assign done = done_r;

  always_comb begin
    if (!neg_r) begin
      q = (ovf_r || q_r[EW-1]) ? {1'b0, {(EW-1){1'b1}}} : q_r;
    end else begin
      q = (ovf_r || (q_r[EW-1] && |q_r[EW-2:0])) ? {1'b1, {(EW-1){1'b0}}} : -q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= nn;
      dsh_r <= dd << (EW - 1);
      ovf_r <= nn >= (dd << EW);
      neg_r <= num[AW-1] ^ den[DW-1];
      q_r   <= '0;
    end else if (cnt_r != '0) begin
      if (ge) rem_r <= rem_r - dsh_r;
      q_r   <= {q_r[EW-2:0], ge};
      dsh_r <= dsh_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && (cnt_r == CNW'(1));
      if (start) begin
        cnt_r <= CNW'(EW);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNW'(1);
      end
    end
  end

endmodule

[design/sjinv_back.sv]
`timescale 1ns / 1ps
module sjinv_back #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                job_vld,
  input  sjinv_pkg::job_hdr_t                 job_hdr,
  input  logic [9*(CW+1)-1:0]                 job_j,
  output logic                                job_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sjinv_pkg::ENT_W-1:0]  res [3][3],
  output logic [sjinv_pkg::REC_W-1:0]         det_recip,
  output sjinv_pkg::status_t                  status
);
  localparam int EW  = sjinv_pkg::ENT_W;
  localparam int RCW = sjinv_pkg::REC_W;
  localparam int DG  = sjinv_pkg::DIG_W;
  localparam int W   = CW + 1;
  localparam int AW  = 2 * W + 1;
  localparam int DW  = 3 * W + 3;
  localparam int ND  = (AW + DG - 1) / DG;
  localparam int MBW = ND * DG;
  localparam int PRW = W + MBW;
  localparam int MCW = $clog2(ND + 2);
  localparam int S   = 2 * FB + 1;
  localparam int K2  = FB + 2;
  localparam int K3  = 2 * FB + 3;
  localparam int RW  = DW + 2;

  sjinv_pkg::bk_state_t state_r, state_nxt;

  logic signed [W-1:0]  jm_r  [3][3];
  logic signed [AW-1:0] adj_r [3][3];
  logic signed [EW-1:0] res_r [3][3];
  logic                 tet_r;
  logic signed [DW-1:0] acc_r, acc_nxt, term;
  logic [1:0]           ii_r, jj_r, dl;
  logic                 ph_r;
  logic [MCW-1:0]       mc_r;
  logic [W-1:0]         ma_r;
  logic [MBW-1:0]       mb_r;
  logic [PRW-1:0]       prod_r;
  logic                 mneg_r;
  logic [RCW-1:0]       rec_r, rec_sat;
  sjinv_pkg::status_t   st_r;

  logic signed [W-1:0]  op_a;
  logic signed [AW-1:0] op_b;
  logic                 op_sub, op_clr, mul_done;
  logic [DW-1:0]        absd, psg;
  logic [RW-1:0]        rq, rq2, rq3, rlim;
  logic                 dv_start, dv_done;
  logic signed [EW-1:0] dv_q;

  assign res       = res_r;
  assign det_recip = rec_r;
  assign status    = st_r;
  assign out_valid = state_r == sjinv_pkg::BK_OUT;
  assign dl        = tet_r ? 2'd2 : 2'd1;
  assign mul_done  = mc_r == MCW'(ND + 1);

  // operand selection for the shared multiplier
  always_comb begin
    op_a   = '0;
    op_b   = '0;
    op_sub = 1'b0;
    op_clr = 1'b0;
    case (state_r)
      sjinv_pkg::BK_ADJ: begin
        if (!ph_r) begin
          op_a   = jm_r[sjinv_pkg::nx3(jj_r)][sjinv_pkg::nx3(ii_r)];
          op_b   = AW'(jm_r[sjinv_pkg::nx3(sjinv_pkg::nx3(jj_r))]
                           [sjinv_pkg::nx3(sjinv_pkg::nx3(ii_r))]);
          op_clr = 1'b1;
        end else begin
          op_a   = jm_r[sjinv_pkg::nx3(jj_r)][sjinv_pkg::nx3(sjinv_pkg::nx3(ii_r))];
          op_b   = AW'(jm_r[sjinv_pkg::nx3(sjinv_pkg::nx3(jj_r))][sjinv_pkg::nx3(ii_r)]);
          op_sub = 1'b1;
        end
      end
      sjinv_pkg::BK_DET: begin
        if (tet_r) begin
          op_a   = jm_r[0][ii_r];
          op_b   = adj_r[ii_r][0];
          op_clr = ii_r == 2'd0;
        end else if (!ph_r) begin
          op_a   = jm_r[0][0];
          op_b   = AW'(jm_r[1][1]);
          op_clr = 1'b1;
        end else begin
          op_a   = jm_r[0][1];
          op_b   = AW'(jm_r[1][0]);
          op_sub = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign psg     = DW'(prod_r);
  assign term    = mneg_r ? -$signed(psg) : $signed(psg);
  assign acc_nxt = (op_clr ? DW'(0) : acc_r) + term;

  // det / 2^d scaling with round half away from zero, then saturate
  assign absd = acc_r[DW-1] ? DW'(-acc_r) : DW'(acc_r);
  assign rq2  = (RW'(absd) + (RW'(1) << (K2 - 1))) >> K2;
  assign rq3  = (RW'(absd) + (RW'(1) << (K3 - 1))) >> K3;
  assign rq   = tet_r ? rq3 : rq2;
  assign rlim = RW'(1) << (RCW - 1);

  always_comb begin
    if (!acc_r[DW-1]) begin
      rec_sat = (rq >= rlim) ? {1'b0, {(RCW-1){1'b1}}} : RCW'(rq);
    end else begin
      rec_sat = (rq > rlim) ? {1'b1, {(RCW-1){1'b0}}} : RCW'(-rq);
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    job_pop   = 1'b0;
    dv_start  = 1'b0;
    case (state_r)
      sjinv_pkg::BK_IDLE: begin
        if (job_vld) begin
          job_pop = 1'b1;
          if (job_hdr.bad_count)  state_nxt = sjinv_pkg::BK_OUT;
          else if (job_hdr.tet)   state_nxt = sjinv_pkg::BK_ADJ;
          else                    state_nxt = sjinv_pkg::BK_ADJ2;
        end
      end
      sjinv_pkg::BK_ADJ2: state_nxt = sjinv_pkg::BK_DET;
      sjinv_pkg::BK_ADJ: begin
        if (mul_done && ph_r && ii_r == 2'd2 && jj_r == 2'd2) state_nxt = sjinv_pkg::BK_DET;
      end
      sjinv_pkg::BK_DET: begin
        if (mul_done && (tet_r ? ii_r == 2'd2 : ph_r)) state_nxt = sjinv_pkg::BK_CHK;
      end
      sjinv_pkg::BK_CHK: begin
        state_nxt = (acc_r == '0) ? sjinv_pkg::BK_OUT : sjinv_pkg::BK_DIVGO;
      end
      sjinv_pkg::BK_DIVGO: begin
        dv_start  = 1'b1;
        state_nxt = sjinv_pkg::BK_DIVW;
      end
      sjinv_pkg::BK_DIVW: begin
        if (dv_done) begin
          state_nxt = (ii_r == dl && jj_r == dl) ? sjinv_pkg::BK_RECIP : sjinv_pkg::BK_DIVGO;
        end
      end
      sjinv_pkg::BK_RECIP: state_nxt = sjinv_pkg::BK_OUT;
      sjinv_pkg::BK_OUT: begin
        if (!out_stall) state_nxt = sjinv_pkg::BK_IDLE;
      end
      default: state_nxt = sjinv_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sjinv_pkg::BK_IDLE;
      ii_r    <= '0;
      jj_r    <= '0;
      ph_r    <= 1'b0;
      mc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sjinv_pkg::BK_IDLE: begin
          ii_r <= '0;
          jj_r <= '0;
          ph_r <= 1'b0;
          mc_r <= '0;
        end
        sjinv_pkg::BK_ADJ: begin
          if (mul_done) begin
            mc_r <= '0;
            ph_r <= ~ph_r;
            if (ph_r) begin
              if (jj_r == 2'd2) begin
                jj_r <= '0;
                ii_r <= sjinv_pkg::nx3(ii_r);
              end else begin
                jj_r <= jj_r + 2'd1;
              end
            end
          end else begin
            mc_r <= mc_r + MCW'(1);
          end
        end
        sjinv_pkg::BK_DET: begin
          if (mul_done) begin
            mc_r <= '0;
            ph_r <= ~ph_r;
            ii_r <= ii_r + 2'd1;
          end else begin
            mc_r <= mc_r + MCW'(1);
          end
        end
        sjinv_pkg::BK_CHK: begin
          ii_r <= '0;
          jj_r <= '0;
        end
        sjinv_pkg::BK_DIVW: begin
          if (dv_done) begin
            if (jj_r == dl) begin
              jj_r <= '0;
              ii_r <= ii_r + 2'd1;
            end else begin
              jj_r <= jj_r + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      sjinv_pkg::BK_IDLE: begin
        if (job_vld) begin
          for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
              jm_r[r][c]  <= job_j[(r*3+c)*W +: W];
              res_r[r][c] <= '0;
            end
          end
          tet_r <= job_hdr.tet;
          rec_r <= '0;
          st_r  <= job_hdr.bad_count ? sjinv_pkg::ST_COUNT : sjinv_pkg::ST_OK;
        end
      end
      sjinv_pkg::BK_ADJ2: begin
        adj_r[0][0] <= AW'(jm_r[1][1]);
        adj_r[0][1] <= -AW'(jm_r[0][1]);
        adj_r[1][0] <= -AW'(jm_r[1][0]);
        adj_r[1][1] <= AW'(jm_r[0][0]);
      end
      sjinv_pkg::BK_ADJ, sjinv_pkg::BK_DET: begin
        if (mc_r == '0) begin
          // load magnitudes; digits of the wide operand go MSB first
          ma_r   <= op_a[W-1] ? W'(-op_a) : W'(op_a);
          mb_r   <= MBW'(op_b[AW-1] ? AW'(-op_b) : AW'(op_b));
          mneg_r <= op_a[W-1] ^ op_b[AW-1] ^ op_sub;
          prod_r <= '0;
        end else if (!mul_done) begin
          prod_r <= (prod_r << DG) + PRW'(ma_r * mb_r[MBW-1 -: DG]);
          mb_r   <= mb_r << DG;
        end else begin
          acc_r <= acc_nxt;
          if (state_r == sjinv_pkg::BK_ADJ && ph_r) adj_r[ii_r][jj_r] <= AW'(acc_nxt);
        end
      end
      sjinv_pkg::BK_CHK: begin
        if (acc_r == '0) st_r <= sjinv_pkg::ST_SINGULAR;
      end
      sjinv_pkg::BK_DIVW: begin
        if (dv_done) res_r[ii_r][jj_r] <= dv_q;
      end
      sjinv_pkg::BK_RECIP: rec_r <= rec_sat;
      default: ;
    endcase
  end

  sjinv_div #(
    .AW (AW),
    .DW (DW),
    .SH (S)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dv_start),
    .num   (adj_r[ii_r][jj_r]),
    .den   (acc_r),
    .done  (dv_done),
    .q     (dv_q)
  );

endmodule

[design/simplex_inverse_jacobian.sv]
`timescale 1ns / 1ps
// Inverse edge Jacobian of a triangle or tetrahedron. Vertices arrive one beat
// each (Q16.16); the beat with in_last_vertex closes the element and gives one
// result beat: 2*inv(J) column by column (zero padded for triangles) and
// det(J)/2^d, all rounded half away from zero and saturated. out_status flags a
// singular Jacobian or a vertex count that does not match in_elem_kind; then
// every other field is zero. The front end takes one vertex per cycle as long as
// its two-entry job queue has room, so vertices of later elements keep flowing
// while the back end works. The back end forms products with a shared multiplier
// that takes 8-bit digits of the (2W+1)-bit operand, W = COORD_WIDTH+1, and
// divides entry by entry in a bit-serial divider. A wrong vertex count goes
// straight to the result beat; a singular Jacobian stops after the determinant.
module simplex_inverse_jacobian #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  // vertex beats
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_elem_kind,
  input  logic signed [31:0]  in_coord_x,
  input  logic signed [31:0]  in_coord_y,
  input  logic signed [31:0]  in_coord_z,
  input  logic                in_last_vertex,
  // result beats
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_m00,
  output logic signed [31:0]  out_m10,
  output logic signed [31:0]  out_m20,
  output logic signed [31:0]  out_m01,
  output logic signed [31:0]  out_m11,
  output logic signed [31:0]  out_m21,
  output logic signed [31:0]  out_m02,
  output logic signed [31:0]  out_m12,
  output logic signed [31:0]  out_m22,
  output logic signed [47:0]  out_det_recip,
  output logic [1:0]          out_status
);
  localparam int W  = COORD_WIDTH + 1;
  localparam int HW = $bits(sjinv_pkg::job_hdr_t);
  localparam int JW = 9 * W + HW;

  sjinv_pkg::job_hdr_t f_hdr, b_hdr;
  logic [9*W-1:0]      f_j;
  logic [JW-1:0]       q_dout;
  logic                push, pop, q_full, q_empty;
  logic signed [31:0]  res [3][3];
  logic [47:0]         rec;
  sjinv_pkg::status_t  st;

  // front end: vertex store, count check, edge differences
  sjinv_front #(
    .CW (COORD_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_elem_kind   (in_elem_kind),
    .in_coord_x     (in_coord_x),
    .in_coord_y     (in_coord_y),
    .in_coord_z     (in_coord_z),
    .in_last_vertex (in_last_vertex),
    .q_full         (q_full),
    .in_stall       (in_stall),
    .push           (push),
    .hdr            (f_hdr),
    .jflat          (f_j)
  );

  // one job per element
  sjinv_fifo #(
    .DW (JW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   ({f_hdr, f_j}),
    .pop   (pop),
    .dout  (q_dout),
    .full  (q_full),
    .empty (q_empty)
  );

  assign b_hdr = sjinv_pkg::job_hdr_t'(q_dout[JW-1 -: HW]);

  // back end: adjugate, determinant, divisions, result register
  sjinv_back #(
    .CW (COORD_WIDTH),
    .FB (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_vld   (~q_empty),
    .job_hdr   (b_hdr),
    .job_j     (q_dout[9*W-1:0]),
    .job_pop   (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res),
    .det_recip (rec),
    .status    (st)
  );

  // res is [row][col]
  assign out_m00       = res[0][0];
  assign out_m10       = res[1][0];
  assign out_m20       = res[2][0];
  assign out_m01       = res[0][1];
  assign out_m11       = res[1][1];
  assign out_m21       = res[2][1];
  assign out_m02       = res[0][2];
  assign out_m12       = res[1][2];
  assign out_m22       = res[2][2];
  assign out_det_recip = rec;
  assign out_status    = st;

endmodule

[design/sjinv_chk.sv]
`timescale 1ns / 1ps
module sjinv_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_m00,
  input logic signed [31:0] out_m10,
  input logic signed [31:0] out_m20,
  input logic signed [31:0] out_m01,
  input logic signed [31:0] out_m11,
  input logic signed [31:0] out_m21,
  input logic signed [31:0] out_m02,
  input logic signed [31:0] out_m12,
  input logic signed [31:0] out_m22,
  input logic signed [47:0] out_det_recip,
  input logic [1:0]         out_status
);

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_status) && $stable(out_det_recip)
                               && $stable(out_m00) && $stable(out_m22))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != sjinv_pkg::ST_OK) |->
      out_m00 == 0 && out_m10 == 0 && out_m20 == 0 && out_m01 == 0 &&
      out_m11 == 0 && out_m21 == 0 && out_m02 == 0 && out_m12 == 0 &&
      out_m22 == 0 && out_det_recip == 0)
    else $error("error result carries nonzero fields");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind simplex_inverse_jacobian sjinv_chk u_chk (.*);
